// File: sv/gmnc_pkg.sv
`default_nettype none

package gmnc_pkg;

  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 1024;

  // register field widths
  localparam int CFG_COL_W = 8;
  localparam int CFG_ROW_W = 11;

  localparam int COL_W  = $clog2(MAX_COLUMNS);      // column index
  localparam int COLS_W = $clog2(MAX_COLUMNS + 1);  // column count
  localparam int ROWS_W = $clog2(MAX_ROWS + 2);     // row position incl. drain rows

  localparam int CNT_W = 4;

  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  localparam logic REG_GRID_COLUMNS = 1'b0;
  localparam logic REG_GRID_ROWS    = 1'b1;

  localparam logic [CFG_COL_W-1:0] GRID_COLUMNS_RST = CFG_COL_W'(128);
  localparam logic [CFG_ROW_W-1:0] GRID_ROWS_RST    = CFG_ROW_W'(1);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // one classified cell on its way to the window
  typedef struct packed {
    logic             mine;
    logic [COL_W-1:0] x;
    logic             has_res;
    logic             mask_l;
    logic             mask_r;
    logic             mask_t;
    logic             mask_b;
  } item_t;

endpackage

`default_nettype wire

// File: sv/gmnc_ifs.sv
`default_nettype none

interface gmnc_in_if;
  logic valid;
  logic ready;
  logic cell_is_mine;
  logic is_drain;

  modport source (output valid, output cell_is_mine, output is_drain, input ready);
  modport sink   (input valid, input cell_is_mine, input is_drain, output ready);
endinterface

interface gmnc_out_if;
  logic                      valid;
  logic                      ready;
  logic                      out_is_mine;
  logic [gmnc_pkg::CNT_W-1:0] mine_count;
  logic                      last_cell;

  modport source (output valid, output out_is_mine, output mine_count, output last_cell,
                  input ready);
  modport sink   (input valid, input out_is_mine, input mine_count, input last_cell,
                  output ready);
endinterface

`default_nettype wire

// File: sv/gmnc_front.sv
`default_nettype none

module gmnc_front (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               fire,
  input  wire logic                               cell_is_mine,
  input  wire logic                               is_drain,
  input  wire logic [gmnc_pkg::CFG_COL_W-1:0]     grid_columns,
  input  wire logic [gmnc_pkg::CFG_ROW_W-1:0]     grid_rows,
  output gmnc_pkg::item_t                         item
);

  logic [gmnc_pkg::COL_W-1:0]  col_pos_r, col_pos_nxt;
  logic [gmnc_pkg::ROWS_W-1:0] row_pos_r, row_pos_nxt;

  logic [gmnc_pkg::COLS_W-1:0] cols, cols_m1, cc;
  logic [gmnc_pkg::ROWS_W-1:0] rows, rows_m1, cr, r;
  logic [gmnc_pkg::COL_W-1:0]  x;
  logic                        have;

  // clamp the registers to the supported range
  always_comb begin
    if (grid_columns == '0) begin
      cols = gmnc_pkg::COLS_W'(1);
    end else if (32'(grid_columns) > 32'(gmnc_pkg::MAX_COLUMNS)) begin
      cols = gmnc_pkg::COLS_W'(gmnc_pkg::MAX_COLUMNS);
    end else begin
      cols = gmnc_pkg::COLS_W'(grid_columns);
    end
    if (grid_rows == '0) begin
      rows = gmnc_pkg::ROWS_W'(1);
    end else if (32'(grid_rows) > 32'(gmnc_pkg::MAX_ROWS)) begin
      rows = gmnc_pkg::ROWS_W'(gmnc_pkg::MAX_ROWS);
    end else begin
      rows = gmnc_pkg::ROWS_W'(grid_rows);
    end
  end

  assign cols_m1 = cols - gmnc_pkg::COLS_W'(1);
  assign rows_m1 = rows - gmnc_pkg::ROWS_W'(1);
  assign r       = row_pos_r;
  assign x       = (gmnc_pkg::COLS_W'(col_pos_r) >= cols) ? gmnc_pkg::COL_W'(cols_m1)
                                                          : col_pos_r;

  // window center trails the input by one row plus one cell
  always_comb begin
    if (x != '0) begin
      have = (r != '0);
      cr   = r - gmnc_pkg::ROWS_W'(1);
      cc   = gmnc_pkg::COLS_W'(x) - gmnc_pkg::COLS_W'(1);
    end else begin
      have = (r >= gmnc_pkg::ROWS_W'(2));
      cr   = r - gmnc_pkg::ROWS_W'(2);
      cc   = cols_m1;
    end
  end

  always_comb begin
    item.mine    = cell_is_mine & ~is_drain;
    item.x       = x;
    item.has_res = have && (cr < rows);
    item.mask_l  = (cc == '0);
    item.mask_r  = (cc == cols_m1);
    item.mask_t  = (cr == '0);
    item.mask_b  = (cr == rows_m1);
  end

  // advance the raster position; restart after the last drain beat
  always_comb begin
    if (r >= rows + gmnc_pkg::ROWS_W'(1)) begin
      col_pos_nxt = '0;
      row_pos_nxt = '0;
    end else if (gmnc_pkg::COLS_W'(x) + gmnc_pkg::COLS_W'(1) >= cols) begin
      col_pos_nxt = '0;
      row_pos_nxt = r + gmnc_pkg::ROWS_W'(1);
    end else begin
      col_pos_nxt = x + gmnc_pkg::COL_W'(1);
      row_pos_nxt = r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
    end else if (fire) begin
      col_pos_r <= col_pos_nxt;
      row_pos_r <= row_pos_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/gmnc_queue.sv
`default_nettype none

module gmnc_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire gmnc_pkg::item_t push_item,
  output logic                 push_ready,
  input  wire logic            pop,
  output gmnc_pkg::item_t      pop_item,
  output logic                 pop_valid
);

  gmnc_pkg::item_t               mem_r [gmnc_pkg::QDEPTH];
  logic [gmnc_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [gmnc_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                          do_push, do_pop;

  assign push_ready = (cnt_r != gmnc_pkg::QCNT_W'(gmnc_pkg::QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push & push_ready;
  assign do_pop     = pop & pop_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + gmnc_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - gmnc_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == gmnc_pkg::QPTR_W'(gmnc_pkg::QDEPTH - 1)) ? '0
                    : wr_ptr_r + gmnc_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == gmnc_pkg::QPTR_W'(gmnc_pkg::QDEPTH - 1)) ? '0
                    : rd_ptr_r + gmnc_pkg::QPTR_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/gmnc_back.sv
`default_nettype none

module gmnc_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire gmnc_pkg::item_t q_item,
  input  wire logic            q_valid,
  output logic                 pop,
  gmnc_out_if.source           out_ch
);

  // one word per column: [1] two rows back, [0] one row back
  logic [1:0] line_mem [gmnc_pkg::MAX_COLUMNS];
  logic [gmnc_pkg::MAX_COLUMNS-1:0] line_vld_r;

  gmnc_pkg::item_t b_item_r;
  logic            b_valid_r;
  logic [1:0]      rd_r;
  logic            rd_ok_r;
  logic            fwd_r;
  logic [1:0]      fwd_data_r;

  logic [8:0]      window_r, window_nxt;
  logic [1:0]      word;
  logic            b_up, b_mid;
  logic [gmnc_pkg::CNT_W-1:0] count;
  logic            adv;

  logic                       out_valid_r;
  logic                       out_mine_r;
  logic [gmnc_pkg::CNT_W-1:0] out_count_r;
  logic                       out_last_r;

  assign adv = !out_valid_r || out_ch.ready;
  assign pop = adv & q_valid;

  // take the word just written when the previous beat hit the same column
  assign word  = fwd_r ? fwd_data_r : (rd_ok_r ? rd_r : 2'b00);
  assign b_up  = word[1];
  assign b_mid = word[0];

  assign window_nxt = {b_item_r.mine, b_mid, b_up, window_r[8:3]};

  always_comb begin
    count = '0;
    for (int c = 0; c < 3; c++) begin
      for (int rw = 0; rw < 3; rw++) begin
        if (!(c == 1 && rw == 1) &&
            !(c == 0 && b_item_r.mask_l) && !(c == 2 && b_item_r.mask_r) &&
            !(rw == 0 && b_item_r.mask_t) && !(rw == 2 && b_item_r.mask_b)) begin
          count = count + gmnc_pkg::CNT_W'(window_nxt[c*3 + rw]);
        end
      end
    end
    if (window_nxt[4]) begin
      count = '0;
    end
  end

  // line buffer read on pop, write back when the beat leaves the window stage
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_r       <= line_mem[q_item.x];
      b_item_r   <= q_item;
      fwd_data_r <= {b_mid, b_item_r.mine};
      if (b_valid_r) begin
        line_mem[b_item_r.x] <= {b_mid, b_item_r.mine};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_vld_r  <= '0;
      b_valid_r   <= 1'b0;
      rd_ok_r     <= 1'b0;
      fwd_r       <= 1'b0;
      window_r    <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r   <= q_valid;
      rd_ok_r     <= line_vld_r[q_item.x];
      fwd_r       <= b_valid_r && (b_item_r.x == q_item.x);
      out_valid_r <= b_valid_r && b_item_r.has_res;
      if (b_valid_r) begin
        line_vld_r[b_item_r.x] <= 1'b1;
        window_r               <= window_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_mine_r  <= window_nxt[4];
      out_count_r <= count;
      out_last_r  <= b_item_r.mask_b & b_item_r.mask_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_is_mine = out_mine_r;
  assign out_ch.mine_count  = out_count_r;
  assign out_ch.last_cell   = out_last_r;

endmodule

`default_nettype wire

// File: sv/grid_mine_neighbor_count.sv
// A cell's result is valid after the beat grid_columns+1 behind it is accepted and
// passes the queue slot and line buffer read, then the window and output register.
// One beat per clock unless stalled; one line buffer read and one write per beat.
// Reset (synchronous, rst_n low): grid_columns 128, grid_rows 1, position and window
// cleared, line buffer valid bits cleared in the same cycle; no clearing pass.
`default_nettype none

module grid_mine_neighbor_count (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  gmnc_in_if.sink                            in_ch,
  gmnc_out_if.source                         out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [gmnc_pkg::APB_AW-1:0]   paddr,
  input  wire logic [gmnc_pkg::APB_DW-1:0]   pwdata,
  output logic      [gmnc_pkg::APB_DW-1:0]   prdata,
  output logic                               pready
);

  logic [gmnc_pkg::CFG_COL_W-1:0] grid_columns_r;
  logic [gmnc_pkg::CFG_ROW_W-1:0] grid_rows_r;
  logic                           cfg_wr;

  gmnc_pkg::item_t front_item, q_item;
  logic            q_ready, q_valid, q_pop, fire;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_columns_r <= gmnc_pkg::GRID_COLUMNS_RST;
      grid_rows_r    <= gmnc_pkg::GRID_ROWS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        gmnc_pkg::REG_GRID_COLUMNS: grid_columns_r <= pwdata[gmnc_pkg::CFG_COL_W-1:0];
        gmnc_pkg::REG_GRID_ROWS:    grid_rows_r    <= pwdata[gmnc_pkg::CFG_ROW_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      gmnc_pkg::REG_GRID_COLUMNS: prdata = gmnc_pkg::APB_DW'(grid_columns_r);
      gmnc_pkg::REG_GRID_ROWS:    prdata = gmnc_pkg::APB_DW'(grid_rows_r);
    endcase
  end

  assign in_ch.ready = q_ready;
  assign fire        = in_ch.valid & q_ready;

  gmnc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .cell_is_mine (in_ch.cell_is_mine),
    .is_drain     (in_ch.is_drain),
    .grid_columns (grid_columns_r),
    .grid_rows    (grid_rows_r),
    .item         (front_item)
  );

  gmnc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fire),
    .push_item  (front_item),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_item   (q_item),
    .pop_valid  (q_valid)
  );

  gmnc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_item  (q_item),
    .q_valid (q_valid),
    .pop     (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
